// ===== rtl/amrp_pkg.sv =====
// Package for the MAC reply parser: widths, character codes, the query echo
// pattern with its fallback table, and the incremental echo matcher step.
// No dependencies.
`timescale 1ns / 1ps

package amrp_pkg;

  typedef logic [7:0] byte_t;

  localparam int LINE_BYTES = 32;
  localparam int WPOS_W     = $clog2(LINE_BYTES);
  localparam int QUERY_LEN  = 9;
  localparam int QPROG_W    = $clog2(QUERY_LEN + 1);
  localparam int PREFIX_LEN = 8;
  localparam int MAC_FIRST  = 8;
  localparam int MAC_CHARS  = 12;
  localparam int MAC_HALF   = MAC_CHARS / 2;
  localparam int HALF_W     = MAC_HALF * 8;
  // Only positions below this are ever read back.
  localparam int STORE_USED = MAC_FIRST + MAC_CHARS;

  localparam byte_t CHAR_T  = 8'h54;
  localparam byte_t CHAR_NL = 8'h0A;

  typedef logic [WPOS_W-1:0]  wpos_t;
  typedef logic [QPROG_W-1:0] qprog_t;

  // "TTM:MAC-?"; the first PREFIX_LEN characters are the reply prefix.
  localparam byte_t QUERY_PAT [QUERY_LEN] = '{
    8'h54, 8'h54, 8'h4D, 8'h3A, 8'h4D, 8'h41, 8'h43, 8'h2D, 8'h3F
  };

  // Fallback length for each matched length of the echo pattern.
  localparam qprog_t QUERY_FAIL [QUERY_LEN] = '{
    QPROG_W'(0), QPROG_W'(0), QPROG_W'(1), QPROG_W'(0), QPROG_W'(0),
    QPROG_W'(0), QPROG_W'(0), QPROG_W'(0), QPROG_W'(0)
  };

  typedef struct packed {
    qprog_t progress;
    logic   hit;
  } qstep_t;

  // One character of the echo matcher. The fallback table never needs more
  // than two hops, so the search loop is fixed at two steps.
  function automatic qstep_t query_step(qprog_t p, byte_t c);
    qprog_t q;
    qstep_t r;
    q = p;
    if (q >= QPROG_W'(QUERY_LEN)) begin
      q = '0;
    end
    for (int i = 0; i < 2; i++) begin
      if (q != '0 && QUERY_PAT[q] != c) begin
        q = QUERY_FAIL[q];
      end
    end
    if (QUERY_PAT[q] == c) begin
      q = q + QPROG_W'(1);
    end
    r.hit = (q == QPROG_W'(QUERY_LEN));
    if (r.hit) begin
      q = '0;
    end
    r.progress = q;
    return r;
  endfunction

endpackage

// ===== rtl/amrp_if.sv =====
// Channel interfaces of the MAC reply parser: byte input and result output,
// each with valid, ready and payload. Depends on amrp_pkg.
`timescale 1ns / 1ps

interface amrp_in_if;
  import amrp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface amrp_out_if;
  import amrp_pkg::*;

  logic              valid;
  logic              ready;
  logic              mac_ready;
  logic [HALF_W-1:0] mac_high_text;
  logic [HALF_W-1:0] mac_low_text;
  logic              captured_now;

  modport source (output valid, output mac_ready, output mac_high_text,
                  output mac_low_text, output captured_now, input ready);
  modport sink   (input valid, input mac_ready, input mac_high_text,
                  input mac_low_text, input captured_now, output ready);
endinterface

// ===== rtl/at_mac_reply_parser.sv =====
// MAC reply parser top level: collects received lines and captures the MAC
// address from a "TTM:MAC-" reply. Depends on amrp_pkg and amrp_if.
`timescale 1ns / 1ps

// Usage
//   in_item  : one received UART byte per item (rx_byte).
//   out_item : exactly one result item per input byte, in order: the sticky
//              mac_ready flag, the twelve captured MAC characters as two
//              48-bit words, and captured_now for the byte that completed
//              the reply.
//   Path     : the byte sits in an input register from its accept edge, and
//              the parse and state update of one pass is loaded from there
//              into the result register that drives out_item.valid.
//   Throughput: one byte per cycle while out_item.ready is high, limited only
//              by one pass through the echo matcher and line store update.
//   Reset    : rst_n low (synchronous) empties both stages, leaves line
//              collection idle, zeroes the line store and the MAC text and
//              clears the done flag. No clearing pass is needed.
//   Stall    : while out_item.ready is low the result register holds its
//              item; the input register then holds too, and in_item.ready
//              drops once that register is full. Nothing is lost or repeated.
//   After a capture every later byte still yields a result item carrying the
//   captured MAC, but no longer touches the parser state.

module at_mac_reply_parser (
  input logic          clk,
  input logic          rst_n,
  amrp_in_if.sink      in_item,
  amrp_out_if.source   out_item
);
  import amrp_pkg::*;

  // Input register stage.
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  s1_adv;
  logic  s1_fire;

  // Result register stage.
  logic              out_valid_r;
  logic              out_mac_ready_r;
  logic [HALF_W-1:0] out_high_r;
  logic [HALF_W-1:0] out_low_r;
  logic              out_captured_r;

  // Parser state.
  logic   in_line_r,  in_line_nxt;
  wpos_t  write_pos_r, write_pos_nxt;
  qprog_t prog_r,     prog_nxt;
  logic   seen_r,     seen_nxt;
  logic   done_r,     done_nxt;
  byte_t  store_r   [STORE_USED];
  byte_t  store_nxt [STORE_USED];
  byte_t  mac_r     [MAC_CHARS];
  byte_t  mac_nxt   [MAC_CHARS];
  logic   captured;

  logic   wr_en;
  wpos_t  wr_pos;
  qstep_t qs;
  logic   seen_adv;
  logic   prefix_ok;
  logic [HALF_W-1:0] high_nxt;
  logic [HALF_W-1:0] low_nxt;

  // The input register moves on when the result register is empty or is
  // being drained this cycle.
  assign s1_adv        = !out_valid_r || out_item.ready;
  assign s1_fire       = s1_valid_r && s1_adv;
  assign in_item.ready = !s1_valid_r || s1_adv;

  assign qs       = query_step(prog_r, s1_byte_r);
  assign seen_adv = seen_r || qs.hit;

  // Prefix check reads the store as it stood; a newline that could still
  // change positions below PREFIX_LEN fails the position test anyway.
  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (store_r[i] != QUERY_PAT[i]) begin
        prefix_ok = 1'b0;
      end
    end
  end

  // Parse one byte.
  always_comb begin
    in_line_nxt   = in_line_r;
    write_pos_nxt = write_pos_r;
    prog_nxt      = prog_r;
    seen_nxt      = seen_r;
    done_nxt      = done_r;
    captured      = 1'b0;
    wr_en         = 1'b0;
    wr_pos        = write_pos_r;
    if (!done_r) begin
      if (!in_line_r) begin
        if (s1_byte_r == CHAR_T) begin
          // Line start: 'T' at position zero, matcher holds one character.
          in_line_nxt   = 1'b1;
          wr_en         = 1'b1;
          wr_pos        = '0;
          write_pos_nxt = WPOS_W'(1);
          prog_nxt      = QPROG_W'(1);
          seen_nxt      = 1'b0;
        end
      end else begin
        wr_en = 1'b1;
        if (write_pos_r == WPOS_W'(LINE_BYTES - 1)) begin
          // Store full: wrap and restart the echo search.
          write_pos_nxt = '0;
          prog_nxt      = '0;
          seen_nxt      = 1'b0;
        end else begin
          write_pos_nxt = write_pos_r + WPOS_W'(1);
          prog_nxt      = qs.progress;
          seen_nxt      = seen_adv;
          if (s1_byte_r == CHAR_NL) begin
            in_line_nxt   = 1'b0;
            write_pos_nxt = '0;
            if (!seen_adv && prefix_ok && write_pos_r >= WPOS_W'(PREFIX_LEN)) begin
              done_nxt = 1'b1;
              captured = 1'b1;
            end
          end
        end
      end
    end
  end

  // Store update; positions at or above STORE_USED are never read back.
  // The store is not cleared on capture: parsing stops there for good.
  always_comb begin
    for (int i = 0; i < STORE_USED; i++) begin
      store_nxt[i] = (wr_en && wr_pos == WPOS_W'(i)) ? s1_byte_r : store_r[i];
    end
  end

  // Capture takes the store with this byte already written.
  always_comb begin
    for (int i = 0; i < MAC_CHARS; i++) begin
      mac_nxt[i] = captured ? store_nxt[MAC_FIRST + i] : mac_r[i];
    end
  end

  // Pack the MAC characters, first character in the top byte.
  always_comb begin
    for (int i = 0; i < MAC_HALF; i++) begin
      high_nxt[HALF_W - 1 - 8 * i -: 8] = mac_nxt[i];
      low_nxt[HALF_W - 1 - 8 * i -: 8]  = mac_nxt[MAC_HALF + i];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_byte_r <= in_item.rx_byte;
    end
  end

  // Parser state: advance only when a byte leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r   <= 1'b0;
      write_pos_r <= '0;
      prog_r      <= '0;
      seen_r      <= 1'b0;
      done_r      <= 1'b0;
      for (int i = 0; i < STORE_USED; i++) begin
        store_r[i] <= '0;
      end
      for (int i = 0; i < MAC_CHARS; i++) begin
        mac_r[i] <= '0;
      end
    end else if (s1_fire) begin
      in_line_r   <= in_line_nxt;
      write_pos_r <= write_pos_nxt;
      prog_r      <= prog_nxt;
      seen_r      <= seen_nxt;
      done_r      <= done_nxt;
      store_r     <= store_nxt;
      mac_r       <= mac_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_mac_ready_r <= done_nxt;
      out_high_r      <= high_nxt;
      out_low_r       <= low_nxt;
      out_captured_r  <= captured;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.mac_ready     = out_mac_ready_r;
  assign out_item.mac_high_text = out_high_r;
  assign out_item.mac_low_text  = out_low_r;
  assign out_item.captured_now  = out_captured_r;

endmodule
